// ===== rtl/core/tun_pkg.sv =====
// ----------------------------------------------------------------------------
// tun_pkg
// Shared types and constants for the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tun_pkg;

    localparam int COORD_W   = 16;
    localparam int MAG_W     = 34;   // |cross component|
    localparam int NORM_W    = 30;   // normalised magnitude
    localparam int SUM_W     = 62;   // sum of squares
    localparam int LEN_W     = 31;   // floor(sqrt(sum))
    localparam int SQRT_STEPS = 31;
    localparam int Q_BITS    = 15;   // quotient bits, q <= 16384
    localparam int NUM_W     = 45;   // m * 16384 + len / 2

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
    } tri_item_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               degenerate;
    } norm_item_t;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] m;
        logic [2:0]            neg;
    } tun_cross_t;

    typedef struct packed {
        logic [2:0][NORM_W-1:0] m;
        logic [2:0]             neg;
        logic                   deg;
    } tun_side_t;

    typedef struct packed {
        logic [2:0][Q_BITS-1:0] q;
        logic [2:0]             neg;
        logic                   deg;
    } tun_quot_t;

endpackage

`default_nettype wire

// ===== rtl/core/tun_cross.sv =====
// ----------------------------------------------------------------------------
// tun_cross
// Edge vectors, partial products and negated cross product magnitudes.
// Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_cross (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire tun_pkg::tri_item_t in_item,
    output logic                    out_valid,
    output tun_pkg::tun_cross_t     out_data
);
    import tun_pkg::*;

    logic signed [16:0] u_reg [3];
    logic signed [16:0] v_reg [3];
    logic signed [16:0] u_next [3];
    logic signed [16:0] v_next [3];
    logic signed [33:0] pa_reg [3];
    logic signed [33:0] pb_reg [3];
    logic signed [34:0] n_diff [3];
    tun_cross_t         cross_reg;
    tun_cross_t         cross_next;
    logic [2:0]         valid_reg;

    always_comb
    begin
        u_next[0] = {in_item.b_x[15], in_item.b_x} - {in_item.a_x[15], in_item.a_x};
        u_next[1] = {in_item.b_y[15], in_item.b_y} - {in_item.a_y[15], in_item.a_y};
        u_next[2] = {in_item.b_z[15], in_item.b_z} - {in_item.a_z[15], in_item.a_z};
        v_next[0] = {in_item.c_x[15], in_item.c_x} - {in_item.a_x[15], in_item.a_x};
        v_next[1] = {in_item.c_y[15], in_item.c_y} - {in_item.a_y[15], in_item.a_y};
        v_next[2] = {in_item.c_z[15], in_item.c_z} - {in_item.a_z[15], in_item.a_z};
    end

    // n = -(u x v)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_diff[i] = {pa_reg[i][33], pa_reg[i]} - {pb_reg[i][33], pb_reg[i]};
            cross_next.neg[i] = n_diff[i][34];
            cross_next.m[i]   = n_diff[i][34] ? MAG_W'(-n_diff[i]) : MAG_W'(n_diff[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= u_next[i];
                v_reg[i] <= v_next[i];
            end
            pa_reg[0] <= u_reg[2] * v_reg[1];
            pb_reg[0] <= u_reg[1] * v_reg[2];
            pa_reg[1] <= u_reg[0] * v_reg[2];
            pb_reg[1] <= u_reg[2] * v_reg[0];
            pa_reg[2] <= u_reg[1] * v_reg[0];
            pb_reg[2] <= u_reg[0] * v_reg[1];
            cross_reg <= cross_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = cross_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tun_norm.sv =====
// ----------------------------------------------------------------------------
// tun_norm
// Bit length search, common shift to 30 bits, squares and sum of squares.
// Four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_norm (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire tun_pkg::tun_cross_t in_data,
    output logic                     out_valid,
    output tun_pkg::tun_side_t       out_side,
    output logic [tun_pkg::SUM_W-1:0] out_sum
);
    import tun_pkg::*;

    logic [MAG_W-1:0]    or_v;
    logic [5:0]          bl_next;
    logic [5:0]          bl_reg;
    tun_cross_t          c_reg;
    logic                deg_reg;
    tun_side_t           side_next;
    tun_side_t           side_reg;
    tun_side_t           side2_reg;
    tun_side_t           side3_reg;
    logic [2*NORM_W-1:0] sq_reg [3];
    logic [SUM_W-1:0]    sum_reg;
    logic [3:0]          valid_reg;

    always_comb
    begin
        or_v    = in_data.m[0] | in_data.m[1] | in_data.m[2];
        bl_next = '0;
        for (int k = 0; k < MAG_W; k++)
        begin
            if (or_v[k])
            begin
                bl_next = 6'(k + 1);
            end
        end
    end

    always_comb
    begin
        side_next.neg = c_reg.neg;
        side_next.deg = deg_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (bl_reg > 6'd30)
            begin
                side_next.m[i] = NORM_W'(c_reg.m[i] >> (bl_reg - 6'd30));
            end
            else
            begin
                side_next.m[i] = NORM_W'(c_reg.m[i] << (6'd30 - bl_reg));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bl_reg    <= bl_next;
            c_reg     <= in_data;
            deg_reg   <= (or_v == '0);
            side_reg  <= side_next;
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= side_reg.m[i] * side_reg.m[i];
            end
            side2_reg <= side_reg;
            sum_reg   <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_side  = side3_reg;
    assign out_sum   = sum_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tun_sqrt.sv =====
// ----------------------------------------------------------------------------
// tun_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_sqrt (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire tun_pkg::tun_side_t   in_side,
    input  wire logic [tun_pkg::SUM_W-1:0] in_sum,
    output logic                      out_valid,
    output tun_pkg::tun_side_t        out_side,
    output logic [tun_pkg::LEN_W-1:0] out_len
);
    import tun_pkg::*;

    logic [63:0] x_reg    [SQRT_STEPS];
    logic [63:0] r_reg    [SQRT_STEPS];
    tun_side_t   side_reg [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] valid_reg;

    // sum < 2^62, so the trial bits run from 2^60 down to 2^0
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        localparam logic [63:0] STEP_BIT = 64'd1 << (60 - 2 * k);
        logic [63:0] x_prev;
        logic [63:0] r_prev;
        logic [63:0] trial;
        logic        v_prev;
        tun_side_t   side_prev;

        if (k == 0)
        begin : g_first
            assign x_prev    = {2'b00, in_sum};
            assign r_prev    = '0;
            assign v_prev    = in_valid;
            assign side_prev = in_side;
        end
        else
        begin : g_rest
            assign x_prev    = x_reg[k-1];
            assign r_prev    = r_reg[k-1];
            assign v_prev    = valid_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        assign trial = r_prev + STEP_BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (x_prev >= trial)
                begin
                    x_reg[k] <= x_prev - trial;
                    r_reg[k] <= (r_prev >> 1) + STEP_BIT;
                end
                else
                begin
                    x_reg[k] <= x_prev;
                    r_reg[k] <= r_prev >> 1;
                end
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[SQRT_STEPS-1];
    assign out_side  = side_reg[SQRT_STEPS-1];
    assign out_len   = r_reg[SQRT_STEPS-1][LEN_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/tun_div.sv =====
// ----------------------------------------------------------------------------
// tun_div
// Rounded division of each magnitude by the length, restoring, one
// quotient bit per stage for all three components in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_div (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire tun_pkg::tun_side_t   in_side,
    input  wire logic [tun_pkg::LEN_W-1:0] in_len,
    output logic                      out_valid,
    output tun_pkg::tun_quot_t        out_quot
);
    import tun_pkg::*;

    logic [NUM_W-1:0]   num_reg [3];
    logic [LEN_W-1:0]   len0_reg;
    tun_side_t          side0_reg;
    logic               valid0_reg;

    logic [NUM_W-1:0]   rem_reg  [Q_BITS][3];
    logic [Q_BITS-1:0]  q_reg    [Q_BITS][3];
    logic [LEN_W-1:0]   len_reg  [Q_BITS];
    tun_side_t          side_reg [Q_BITS];
    logic [Q_BITS-1:0]  valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
        end
        else if (en)
        begin
            valid0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= {1'b0, in_side.m[i], 14'd0} + NUM_W'(in_len >> 1);
            end
            len0_reg  <= in_len;
            side0_reg <= in_side;
        end
    end

    for (genvar j = 0; j < Q_BITS; j++)
    begin : g_step
        localparam int SH = Q_BITS - 1 - j;
        logic [NUM_W-1:0]  rem_prev [3];
        logic [Q_BITS-1:0] q_prev   [3];
        logic [LEN_W-1:0]  len_prev;
        tun_side_t         side_prev;
        logic              v_prev;
        logic [NUM_W:0]    dvs;

        if (j == 0)
        begin : g_first
            assign rem_prev  = num_reg;
            assign q_prev    = '{default: '0};
            assign len_prev  = len0_reg;
            assign side_prev = side0_reg;
            assign v_prev    = valid0_reg;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[j-1];
            assign q_prev    = q_reg[j-1];
            assign len_prev  = len_reg[j-1];
            assign side_prev = side_reg[j-1];
            assign v_prev    = valid_reg[j-1];
        end

        assign dvs = (NUM_W+1)'(len_prev) << SH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if ({1'b0, rem_prev[i]} >= dvs)
                    begin
                        rem_reg[j][i] <= NUM_W'({1'b0, rem_prev[i]} - dvs);
                        q_reg[j][i]   <= q_prev[i] | (Q_BITS'(1) << SH);
                    end
                    else
                    begin
                        rem_reg[j][i] <= rem_prev[i];
                        q_reg[j][i]   <= q_prev[i];
                    end
                end
                len_reg[j]  <= len_prev;
                side_reg[j] <= side_prev;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            out_quot.q[i] = q_reg[Q_BITS-1][i];
        end
        out_quot.neg = side_reg[Q_BITS-1].neg;
        out_quot.deg = side_reg[Q_BITS-1].deg;
    end

    assign out_valid = valid_reg[Q_BITS-1];

endmodule

`default_nettype wire

// ===== rtl/core/triangle_unit_normal_core.sv =====
// ----------------------------------------------------------------------------
// triangle_unit_normal_core
// Unit face normal of a triangle given as three Q8.8 points, Q1.14 result.
// ----------------------------------------------------------------------------
// Fully pipelined: one item may enter every cycle while norm_stall does not
// hold a result. Each item passes through 3 cross product stages, 4 normalise
// and sum-of-squares stages, 31 square root stages, 16 divider stages and
// the output register. The pipeline advances as a whole; while a result
// waits on norm_stall the block stalls its input. Collinear points give a
// zero normal with degenerate set.
`default_nettype none

module triangle_unit_normal_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                tri_valid,
    output logic                     tri_stall,
    input  wire tun_pkg::tri_item_t  tri_item,
    output logic                     norm_valid,
    input  wire logic                norm_stall,
    output tun_pkg::norm_item_t      norm_item
);
    import tun_pkg::*;

    logic        en;
    logic        cross_valid;
    tun_cross_t  cross_data;
    logic        norm_stage_valid;
    tun_side_t   norm_side;
    logic [SUM_W-1:0] norm_sum;
    logic        sqrt_valid;
    tun_side_t   sqrt_side;
    logic [LEN_W-1:0] sqrt_len;
    logic        div_valid;
    tun_quot_t   div_quot;
    logic [15:0] comp [3];
    norm_item_t  res_next;
    norm_item_t  res_reg;
    logic        res_valid_reg;

    assign en        = !(res_valid_reg && norm_stall);
    assign tri_stall = !en;

    tun_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (tri_valid),
        .in_item   (tri_item),
        .out_valid (cross_valid),
        .out_data  (cross_data)
    );

    tun_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cross_valid),
        .in_data   (cross_data),
        .out_valid (norm_stage_valid),
        .out_side  (norm_side),
        .out_sum   (norm_sum)
    );

    tun_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (norm_stage_valid),
        .in_side   (norm_side),
        .in_sum    (norm_sum),
        .out_valid (sqrt_valid),
        .out_side  (sqrt_side),
        .out_len   (sqrt_len)
    );

    tun_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_valid),
        .in_side   (sqrt_side),
        .in_len    (sqrt_len),
        .out_valid (div_valid),
        .out_quot  (div_quot)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (div_quot.deg)
            begin
                comp[i] = '0;
            end
            else if (div_quot.neg[i])
            begin
                comp[i] = -{1'b0, div_quot.q[i]};
            end
            else
            begin
                comp[i] = {1'b0, div_quot.q[i]};
            end
        end
        res_next.normal_x   = comp[0];
        res_next.normal_y   = comp[1];
        res_next.normal_z   = comp[2];
        res_next.degenerate = div_quot.deg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign norm_valid = res_valid_reg;
    assign norm_item  = res_reg;

endmodule

`default_nettype wire

// ===== tb/sv/triangle_unit_normal_core_tb.sv =====
// ----------------------------------------------------------------------------
// triangle_unit_normal_core_tb
// Streams triangles through the unit normal core and checks every normal
// against a bit-exact predictor, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_unit_normal_core_tb;

    import tun_pkg::*;

    class normal_scoreboard;
        norm_item_t pending_normals[$];
        int         errors;

        function automatic logic [63:0] int_sqrt(logic [63:0] x);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function automatic norm_item_t unit_normal(tri_item_t t);
            longint      ux, uy, uz, vx, vy, vz;
            longint      n[3];
            logic [63:0] m[3];
            logic [63:0] mx, s, len, q;
            int          bl;
            norm_item_t  r;
            ux = longint'(t.b_x) - longint'(t.a_x);
            uy = longint'(t.b_y) - longint'(t.a_y);
            uz = longint'(t.b_z) - longint'(t.a_z);
            vx = longint'(t.c_x) - longint'(t.a_x);
            vy = longint'(t.c_y) - longint'(t.a_y);
            vz = longint'(t.c_z) - longint'(t.a_z);
            n[0] = -(uy * vz - uz * vy);
            n[1] = -(uz * vx - ux * vz);
            n[2] = -(ux * vy - uy * vx);
            r = '0;
            mx = 0;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = n[i] < 0 ? -n[i] : n[i];
                if (m[i] > mx)
                    mx = m[i];
            end
            if (mx == 0)
            begin
                r.degenerate = 1'b1;
                return r;
            end
            bl = 0;
            while (bl < 64 && (mx >> bl) != 0)
                bl++;
            for (int i = 0; i < 3; i++)
                m[i] = bl > 30 ? m[i] >> (bl - 30) : m[i] << (30 - bl);
            s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
            len = int_sqrt(s);
            for (int i = 0; i < 3; i++)
            begin
                q = (m[i] * 64'd16384 + (len >> 1)) / len;
                if (n[i] < 0)
                    q = -q;
                if (i == 0) r.normal_x = q[15:0];
                else if (i == 1) r.normal_y = q[15:0];
                else r.normal_z = q[15:0];
            end
            return r;
        endfunction

        function void note_triangle(tri_item_t t);
            pending_normals.push_back(unit_normal(t));
        endfunction

        function void check_normal(norm_item_t got);
            norm_item_t e;
            if (pending_normals.size() == 0)
            begin
                $error("unexpected normal %h", got);
                errors++;
                return;
            end
            e = pending_normals.pop_front();
            if (got.normal_x !== e.normal_x)
            begin
                $error("normal_x exp %0d got %0d", e.normal_x, got.normal_x);
                errors++;
            end
            if (got.normal_y !== e.normal_y)
            begin
                $error("normal_y exp %0d got %0d", e.normal_y, got.normal_y);
                errors++;
            end
            if (got.normal_z !== e.normal_z)
            begin
                $error("normal_z exp %0d got %0d", e.normal_z, got.normal_z);
                errors++;
            end
            if (got.degenerate !== e.degenerate)
            begin
                $error("degenerate exp %0b got %0b", e.degenerate, got.degenerate);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       tri_valid;
    logic       tri_stall;
    tri_item_t  tri_item;
    logic       norm_valid;
    logic       norm_stall;
    norm_item_t norm_item;

    normal_scoreboard sb;
    int  send_idle_pct;
    int  stall_pct;
    bit  hold_off;

    triangle_unit_normal_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tri_valid  (tri_valid),
        .tri_stall  (tri_stall),
        .tri_item   (tri_item),
        .norm_valid (norm_valid),
        .norm_stall (norm_stall),
        .norm_item  (norm_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    // accepted items
    always @(posedge clk)
    begin
        if (rst_n && tri_valid && !tri_stall)
            sb.note_triangle(tri_item);
        if (rst_n && norm_valid && !norm_stall)
            sb.check_normal(norm_item);
    end

    // receiver stall
    initial
    begin
        norm_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                norm_stall <= 1'b1;
                repeat (200) @(negedge clk);
                hold_off = 1'b0;
            end
            norm_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(16)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_triangle(tri_item_t t);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            tri_valid <= 1'b0;
            @(negedge clk);
        end
        tri_valid <= 1'b1;
        tri_item  <= t;
        @(posedge clk);
        while (tri_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(int count);
        tri_item_t t;
        for (int i = 0; i < count; i++)
        begin
            t = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
            case ($urandom_range(4))
                0:
                begin
                    // collinear: c = a + k*(b - a)
                    t.c_x = t.a_x + 16'(2 * (t.b_x - t.a_x));
                    t.c_y = t.a_y + 16'(2 * (t.b_y - t.a_y));
                    t.c_z = t.a_z + 16'(2 * (t.b_z - t.a_z));
                    if ($urandom_range(1)) t = {t.a_x, t.a_y, t.a_z, t.a_x, t.a_y,
                        t.a_z, t.c_x, t.c_y, t.c_z};
                end
                1:
                begin
                    t.a_x = pick_coord(); t.a_y = pick_coord(); t.a_z = pick_coord();
                    t.b_x = pick_coord(); t.b_y = pick_coord(); t.b_z = pick_coord();
                    t.c_x = pick_coord(); t.c_y = pick_coord(); t.c_z = pick_coord();
                end
                2:
                begin
                    // small triangle near a
                    t.b_x = t.a_x + 16'($urandom_range(6)) - 16'd3;
                    t.b_y = t.a_y + 16'($urandom_range(6)) - 16'd3;
                    t.b_z = t.a_z + 16'($urandom_range(6)) - 16'd3;
                    t.c_x = t.a_x + 16'($urandom_range(6)) - 16'd3;
                    t.c_y = t.a_y + 16'($urandom_range(6)) - 16'd3;
                    t.c_z = t.a_z + 16'($urandom_range(6)) - 16'd3;
                end
                default: ;
            endcase
            send_triangle(t);
        end
        tri_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_normals.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        sb = new();
        tri_valid = 1'b0;
        tri_item = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: axis-aligned, extremes, degenerate
        send_triangle('0);
        send_triangle({16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0});
        send_triangle({16'd0, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd256, 16'd0, 16'd0});
        send_triangle({16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd0});
        send_triangle({16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1});
        send_triangle({16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
                       16'h8000, 16'h7FFF, 16'h8000});
        send_triangle({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
                       16'h7FFF, 16'h8000, 16'h8000});
        send_triangle({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                       16'h8000, 16'h8000, 16'h7FFF});
        send_triangle({9{16'hFFFF}});
        send_triangle({9{16'h7FFF}});
        send_triangle({16'd1, 16'd2, 16'd3, 16'd2, 16'd4, 16'd6, 16'd3, 16'd6, 16'd9});
        send_triangle({16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd2, 16'd2, 16'd3});
        send_triangle({16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                       16'hAAAA, 16'h5555, 16'h5555});
        tri_valid <= 1'b0;
        drain();

        send_random(120);
        send_idle_pct = 68;
        send_random(100);
        send_idle_pct = 0;
        stall_pct = 68;
        send_random(100);
        send_idle_pct = 37;
        stall_pct = 37;
        send_random(80);
        // long hold-off so the pipeline fills and backs up
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b1;
        send_random(100);
        drain();
        send_random(20);

        drain();
        repeat (80) @(negedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
